/* rtl/core/bcfd_pkg.sv */
// Shared types, widths and CRC6 constants for the BiSS-C frame decoder.
`default_nettype none

package bcfd_pkg;

    localparam int POSITION_BITS = 22;
    localparam int TURN_BITS     = 10;
    localparam int RAW_BITS      = 64;
    localparam int MASKED_BITS   = 62;
    localparam int FRAME_BITS    = POSITION_BITS + 10;
    localparam int DATA_BITS     = POSITION_BITS + 2;
    localparam int CRC_BITS      = 6;
    localparam int COMB_BITS     = 32;
    localparam int COUNT_BITS    = 32;
    localparam int SHIFT_BITS    = $clog2(RAW_BITS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam int OUT_FIELD_BITS = POSITION_BITS + TURN_BITS + COMB_BITS + COUNT_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_BITS = 4;

    localparam logic [CRC_BITS-1:0] CRC6_POLY_LOW = 6'h03;

    typedef logic [CRC_BITS-1:0] crc_col_t [DATA_BITS];

    // Item passed from the front end to the back end.
    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic                     error_bit;
        logic                     warning_bit;
        logic                     crc_bad;
        logic                     no_start;
    } frame_item_t;

    // CRC6 is linear with a zero seed: each data bit contributes a fixed
    // column, the register contents after a single one followed by zeros.
    function automatic crc_col_t crc6_columns();
        crc_col_t        cols;
        logic [CRC_BITS-1:0] c;
        c = CRC6_POLY_LOW;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            cols[i] = c;
            c = {c[CRC_BITS-2:0], 1'b0} ^ (c[CRC_BITS-1] ? CRC6_POLY_LOW : '0);
        end
        return cols;
    endfunction

    localparam crc_col_t CRC6_COL = crc6_columns();

endpackage

`default_nettype wire

/* rtl/core/bcfd_front.sv */
// Front end: start bit search, alignment, field extraction and CRC6 check.
`default_nettype none

module bcfd_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bcfd_pkg::RAW_BITS-1:0] in_frame,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bcfd_pkg::frame_item_t              out_item
);
    import bcfd_pkg::*;

    logic                    s1_valid_reg;
    logic [MASKED_BITS-1:0]  s1_frame_reg;
    logic [SHIFT_BITS-1:0]   s1_shift_reg;
    logic                    s1_nostart_reg;
    logic                    s2_valid_reg;
    frame_item_t             s2_item_reg;

    logic [MASKED_BITS-1:0]  masked;
    logic [SHIFT_BITS-1:0]   lead;
    logic [SHIFT_BITS-1:0]   shift_next;
    logic                    s2_adv;
    logic                    s1_load;
    logic [RAW_BITS-1:0]     shifted;
    logic [FRAME_BITS-1:0]   aligned;
    logic [DATA_BITS-1:0]    data;
    logic [CRC_BITS-1:0]     crc_rx;
    logic [CRC_BITS-1:0]     crc_calc;
    frame_item_t             item_next;

    assign masked = in_frame[MASKED_BITS-1:0];

    // priority encoder: highest set bit wins
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < MASKED_BITS; i++)
        begin
            if (masked[i])
            begin
                lead = SHIFT_BITS'(i);
            end
        end
    end

    assign shift_next = SHIFT_BITS'(RAW_BITS - 1) - lead;

    assign s2_adv   = !s2_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s2_adv;
    assign s1_load  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_frame_reg   <= masked;
            s1_shift_reg   <= shift_next;
            s1_nostart_reg <= (masked == '0);
        end
        if (s2_adv && s1_valid_reg)
        begin
            s2_item_reg <= item_next;
        end
    end

    // start bit lands on the MSB; zeros fill in below a late start bit
    assign shifted = {{(RAW_BITS - MASKED_BITS){1'b0}}, s1_frame_reg} << s1_shift_reg;
    assign aligned = shifted[RAW_BITS-1 -: FRAME_BITS];
    assign crc_rx  = aligned[CRC_BITS-1:0];
    assign data    = aligned[CRC_BITS +: DATA_BITS];

    always_comb
    begin
        crc_calc = '0;
        for (int i = 0; i < DATA_BITS; i++)
        begin
            if (data[i])
            begin
                crc_calc = crc_calc ^ CRC6_COL[i];
            end
        end
    end

    always_comb
    begin
        item_next.position    = data[DATA_BITS-1:2];
        item_next.error_bit   = data[1];
        item_next.warning_bit = data[0];
        item_next.crc_bad     = (~crc_calc) != crc_rx;
        item_next.no_start    = s1_nostart_reg;
        if (s1_nostart_reg)
        begin
            item_next.error_bit   = 1'b0;
            item_next.warning_bit = 1'b0;
            item_next.crc_bad     = 1'b0;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

`default_nettype wire

/* rtl/core/bcfd_queue.sv */
// Short FIFO between the decode front end and the tracking back end.
`default_nettype none

module bcfd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bcfd_pkg::frame_item_t in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output bcfd_pkg::frame_item_t out_item
);
    import bcfd_pkg::*;

    frame_item_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCNT_BITS-1:0]   count_reg;
    logic                   push;
    logic                   pop;

    assign in_ready  = count_reg != QCNT_BITS'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bcfd_back.sv */
// Back end: multiturn tracking, CRC error count and the result register.
`default_nettype none

module bcfd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire bcfd_pkg::frame_item_t             in_item,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bcfd_pkg::POSITION_BITS-1:0]     position,
    output logic [bcfd_pkg::TURN_BITS-1:0]         turn_count,
    output logic [bcfd_pkg::COMB_BITS-1:0]         combined_position,
    output logic                                   crc_mismatch,
    output logic                                   no_start_bit,
    output logic                                   error_flag_bit,
    output logic                                   warning_flag_bit,
    output logic [bcfd_pkg::COUNT_BITS-1:0]        crc_error_total
);
    import bcfd_pkg::*;

    localparam logic signed [POSITION_BITS:0] HALF_REV =
        (POSITION_BITS + 1)'(1) << (POSITION_BITS - 1);

    logic [POSITION_BITS-1:0]        prev_pos_reg;
    logic [POSITION_BITS-1:0]        prev_pos_next;
    logic signed [TURN_BITS-1:0]     turns_reg;
    logic signed [TURN_BITS-1:0]     turns_next;
    logic [COUNT_BITS-1:0]           count_reg;
    logic [COUNT_BITS-1:0]           count_next;
    logic                            out_valid_reg;
    logic [POSITION_BITS-1:0]        pos_out_reg;
    logic [TURN_BITS-1:0]            turn_out_reg;
    logic [COMB_BITS-1:0]            comb_out_reg;
    logic                            crc_out_reg;
    logic                            nostart_out_reg;
    logic                            err_out_reg;
    logic                            warn_out_reg;
    logic [COUNT_BITS-1:0]           count_out_reg;

    logic                            take;
    logic signed [POSITION_BITS:0]   diff;
    logic [COMB_BITS-1:0]            turns_ext;
    logic [COMB_BITS-1:0]            comb_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign diff = $signed({1'b0, in_item.position}) - $signed({1'b0, prev_pos_reg});

    always_comb
    begin
        prev_pos_next = prev_pos_reg;
        turns_next    = turns_reg;
        count_next    = count_reg;
        if (!in_item.no_start)
        begin
            prev_pos_next = in_item.position;
            if (diff > HALF_REV)
            begin
                turns_next = turns_reg - TURN_BITS'(1);
            end
            else if (diff < -HALF_REV)
            begin
                turns_next = turns_reg + TURN_BITS'(1);
            end
            if (in_item.crc_bad)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    assign turns_ext = COMB_BITS'(turns_next);
    assign comb_next = {turns_ext[COMB_BITS-1-POSITION_BITS:0], prev_pos_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg  <= '0;
            turns_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_pos_reg <= prev_pos_next;
                turns_reg    <= turns_next;
                count_reg    <= count_next;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_out_reg     <= prev_pos_next;
            turn_out_reg    <= turns_next;
            comb_out_reg    <= comb_next;
            crc_out_reg     <= in_item.crc_bad;
            nostart_out_reg <= in_item.no_start;
            err_out_reg     <= in_item.error_bit;
            warn_out_reg    <= in_item.warning_bit;
            count_out_reg   <= count_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign position          = pos_out_reg;
    assign turn_count        = turn_out_reg;
    assign combined_position = comb_out_reg;
    assign crc_mismatch      = crc_out_reg;
    assign no_start_bit      = nostart_out_reg;
    assign error_flag_bit    = err_out_reg;
    assign warning_flag_bit  = warn_out_reg;
    assign crc_error_total   = count_out_reg;

endmodule

`default_nettype wire

/* rtl/core/biss_c_frame_decoder_top.sv */
// Top level of the BiSS-C frame decoder: front end, queue and back end.
//
//  channel | direction | contents
//  --------+-----------+------------------------------------------------------
//  s_axis  | in        | tdata[63:0] raw frame, first received byte in [63:56]
//  m_axis  | out       | tdata position, turns, combined, CRC error total;
//          |           | tuser crc_mismatch, no_start_bit, error, warning
//
// One frame per cycle sustained unless m_axis stalls. On its way to the result
// a frame passes two front-end stages (start bit search, then shift and CRC6),
// the two-entry queue, and the result register in the back end.
// Reset clears the turn counter, last position and CRC error count.
// A stalled m_axis fills the queue and then the front end before s_axis stalls.
`default_nettype none

module biss_c_frame_decoder_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [bcfd_pkg::RAW_BITS-1:0]        s_axis_tdata,  // raw_frame
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // position, turn_count, combined_position, crc_error_total
    output logic [bcfd_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
    // crc_mismatch, no_start_bit, error_flag_bit, warning_flag_bit
    output logic [bcfd_pkg::OUT_TUSER_BITS-1:0]       m_axis_tuser
);
    import bcfd_pkg::*;

    frame_item_t              front_item;
    logic                     front_valid;
    logic                     front_ready;
    frame_item_t              queue_item;
    logic                     queue_valid;
    logic                     queue_ready;

    logic [POSITION_BITS-1:0] position;
    logic [TURN_BITS-1:0]     turn_count;
    logic [COMB_BITS-1:0]     combined_position;
    logic                     crc_mismatch;
    logic                     no_start_bit;
    logic                     error_flag_bit;
    logic                     warning_flag_bit;
    logic [COUNT_BITS-1:0]    crc_error_total;

    bcfd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_frame  (s_axis_tdata),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    bcfd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    bcfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (queue_valid),
        .in_ready          (queue_ready),
        .in_item           (queue_item),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .position          (position),
        .turn_count        (turn_count),
        .combined_position (combined_position),
        .crc_mismatch      (crc_mismatch),
        .no_start_bit      (no_start_bit),
        .error_flag_bit    (error_flag_bit),
        .warning_flag_bit  (warning_flag_bit),
        .crc_error_total   (crc_error_total)
    );

    assign m_axis_tdata = OUT_TDATA_BITS'({crc_error_total, combined_position,
                                           turn_count, position});
    assign m_axis_tuser = {warning_flag_bit, error_flag_bit, no_start_bit, crc_mismatch};

endmodule

`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the BiSS-C frame decoder: CRC6, start bit search, multiturn.
`timescale 1ns / 1ps

module tb;
    import bcfd_pkg::*;

    localparam int          IDLE_PCT = 14;
    localparam int          SPIN_FRAMES = 430;
    localparam int          MIX_FRAMES = 300;
    localparam logic [POSITION_BITS-1:0] HALF_TURN = POSITION_BITS'(1) << (POSITION_BITS - 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic [TURN_BITS-1:0]     turns;
        logic [COMB_BITS-1:0]     combined;
        logic                     crc_bad;
        logic                     no_start;
        logic                     error_bit;
        logic                     warning_bit;
        logic [COUNT_BITS-1:0]    crc_total;
    } decoded_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [RAW_BITS-1:0]       s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic [OUT_TUSER_BITS-1:0] m_axis_tuser;

    // decoder state as the testbench tracks it
    logic [POSITION_BITS-1:0]  last_position = '0;
    logic [TURN_BITS-1:0]      turn_counter = '0;
    logic [COUNT_BITS-1:0]     crc_error_count = '0;

    decoded_t                  pending_decodes[$];
    int                        errors = 0;
    int                        frames_sent = 0;
    int                        bad_crc_frames = 0;
    int                        startless_frames = 0;
    int                        sign_flips = 0;
    bit                        calm = 1'b0;

    biss_c_frame_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5ms;
        $display("%0t: timeout, %0d decodes still pending", $time, pending_decodes.size());
        $display("Some tests failed");
        $finish;
    end

    // Inverted result is what the encoder sends; this returns the raw register.
    function automatic logic [CRC_BITS-1:0] crc6_of(input logic [DATA_BITS-1:0] data);
        logic [CRC_BITS-1:0] r;
        logic                fb;
        int                  i;
        r = '0;
        for (i = DATA_BITS - 1; i >= 0; i--)
        begin
            fb = r[CRC_BITS-1] ^ data[i];
            r = {r[CRC_BITS-2:0], 1'b0} ^ (fb ? CRC6_POLY_LOW : '0);
        end
        return r;
    endfunction

    // Places a 32-bit BiSS word with its start bit at bit msb; junk fills the bits
    // below the word and the two masked top bits.
    function automatic logic [RAW_BITS-1:0] build_frame(input logic [POSITION_BITS-1:0] pos,
                                                        input logic err, input logic warn,
                                                        input logic cds,
                                                        input logic [CRC_BITS-1:0] crc_flip,
                                                        input int msb,
                                                        input logic [RAW_BITS-1:0] junk);
        logic [FRAME_BITS-1:0] word;
        logic [RAW_BITS-1:0]   f;
        logic [RAW_BITS-1:0]   low_mask;
        word = {1'b1, cds, pos, err, warn, ~crc6_of({pos, err, warn}) ^ crc_flip};
        if (msb >= FRAME_BITS - 1)
        begin
            low_mask = (64'd1 << (msb - FRAME_BITS + 1)) - 64'd1;
            f = ({32'b0, word} << (msb - FRAME_BITS + 1)) | (junk & low_mask);
        end
        else
            f = {32'b0, word} >> (FRAME_BITS - 1 - msb);
        f[RAW_BITS-1:MASKED_BITS] = junk[RAW_BITS-1:MASKED_BITS];
        return f;
    endfunction

    function automatic decoded_t decode_frame(input logic [RAW_BITS-1:0] raw);
        logic [MASKED_BITS-1:0]   masked;
        logic [RAW_BITS-1:0]      aligned;
        logic [FRAME_BITS-1:0]    word;
        logic [DATA_BITS-1:0]     data;
        logic [POSITION_BITS-1:0] pos;
        logic [TURN_BITS-1:0]     old_turns;
        longint                   delta;
        int                       msb;
        decoded_t                 d;
        masked = raw[MASKED_BITS-1:0];
        d = '0;
        if (masked == '0)
        begin
            d.no_start = 1'b1;
            startless_frames++;
        end
        else
        begin
            msb = MASKED_BITS - 1;
            while (!masked[msb])
                msb--;
            aligned = {2'b00, masked} << (RAW_BITS - 1 - msb);
            word = aligned[RAW_BITS-1 -: FRAME_BITS];
            data = word[CRC_BITS +: DATA_BITS];
            pos = data[DATA_BITS-1:2];
            d.error_bit = data[1];
            d.warning_bit = data[0];
            d.crc_bad = (~crc6_of(data)) != word[CRC_BITS-1:0];
            if (d.crc_bad)
            begin
                crc_error_count++;
                bad_crc_frames++;
            end
            // multiturn follows the position even when the CRC is bad
            old_turns = turn_counter;
            delta = longint'(pos) - longint'(last_position);
            if (delta > longint'(HALF_TURN))
                turn_counter = turn_counter - 1'b1;
            else if (-delta > longint'(HALF_TURN))
                turn_counter = turn_counter + 1'b1;
            if (old_turns[TURN_BITS-1] != turn_counter[TURN_BITS-1])
                sign_flips++;
            last_position = pos;
        end
        d.position = last_position;
        d.turns = turn_counter;
        d.combined = {turn_counter, last_position};
        d.crc_total = crc_error_count;
        return d;
    endfunction

    task automatic send_frame(input logic [RAW_BITS-1:0] raw);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= raw;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_decodes.push_back(decode_frame(raw));
        frames_sent++;
    endtask

    task automatic wait_all_decoded();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_decodes.size() != 0);
    endtask

    function automatic logic [RAW_BITS-1:0] random_raw();
        return {$urandom, $urandom};
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] actual);
        if (want !== actual)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, actual);
            errors++;
        end
    endfunction

    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_decodes.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual tdata=%h tuser=%h",
                         $time, m_axis_tdata, m_axis_tuser);
                errors++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_field("position", want.position, m_axis_tdata[0 +: POSITION_BITS]);
                check_field("turn_count", want.turns,
                            m_axis_tdata[POSITION_BITS +: TURN_BITS]);
                check_field("combined_position", want.combined,
                            m_axis_tdata[POSITION_BITS + TURN_BITS +: COMB_BITS]);
                check_field("crc_error_total", want.crc_total,
                            m_axis_tdata[POSITION_BITS + TURN_BITS + COMB_BITS +: COUNT_BITS]);
                check_field("crc_mismatch", want.crc_bad, m_axis_tuser[0]);
                check_field("no_start_bit", want.no_start, m_axis_tuser[1]);
                check_field("error_flag_bit", want.error_bit, m_axis_tuser[2]);
                check_field("warning_flag_bit", want.warning_bit, m_axis_tuser[3]);
            end
        end
    end

    // Frames whose unmasked bits are all zero, with each pattern in the masked pair.
    task automatic test_no_start();
        send_frame(64'h0000_0000_0000_0000);
        send_frame(64'hC000_0000_0000_0000);
        send_frame(64'h4000_0000_0000_0000);
        send_frame(64'h8000_0000_0000_0000);
        wait_all_decoded();
    endtask

    task automatic test_field_extremes();
        send_frame(build_frame('0, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(build_frame(POS_MAX, 1'b1, 1'b1, 1'b1, '0, 61, '1));
        send_frame(build_frame(POS_MAX, 1'b1, 1'b0, 1'b0, 6'h3F, 61, '0));
        send_frame(build_frame('0, 1'b0, 1'b1, 1'b1, 6'h01, 61, random_raw()));
        send_frame(64'hFFFF_FFFF_FFFF_FFFF);
        send_frame(64'h3FFF_FFFF_FFFF_FFFF);
        wait_all_decoded();
    endtask

    // Start bit at the top, at the exact fit, and below it (late start, zero fill).
    task automatic test_start_bit_placement();
        send_frame(build_frame(22'h2A_AAAA, 1'b0, 1'b1, 1'b0, '0, 61, random_raw()));
        send_frame(build_frame(22'h15_5555, 1'b1, 1'b0, 1'b1, '0, 31, random_raw()));
        send_frame(build_frame(22'h00_0FFF, 1'b0, 1'b0, 1'b0, '0, 30, random_raw()));
        send_frame(build_frame(22'h3F_0000, 1'b1, 1'b1, 1'b0, '0, 5, random_raw()));
        send_frame(64'h0000_0000_0000_0001);
        wait_all_decoded();
    endtask

    task automatic test_half_turn();
        send_frame(build_frame('0, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(build_frame(HALF_TURN, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(build_frame('0, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(build_frame(HALF_TURN + 1, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(build_frame('0, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        // bad CRC still moves the turn counter
        send_frame(build_frame(HALF_TURN + 5, 1'b0, 1'b0, 1'b0, 6'h3F, 61, '0));
        send_frame(build_frame(22'd2, 1'b0, 1'b0, 1'b0, 6'h01, 61, '0));
        send_frame(build_frame(POS_MAX, 1'b0, 1'b0, 1'b0, '0, 61, '0));
        send_frame(64'h8000_0000_0000_0000);
        wait_all_decoded();
    endtask

    // Turn backwards by just under half a turn per frame so the counter runs
    // well into negative values and the combined position goes negative.
    task automatic test_turn_wrap();
        logic [POSITION_BITS-1:0] pos;
        logic [CRC_BITS-1:0]      flip;
        int                       n;
        for (n = 0; n < SPIN_FRAMES; n++)
        begin
            calm = (n < 150);
            pos = last_position - (HALF_TURN - POSITION_BITS'($urandom_range(1, 1000)));
            flip = ($urandom_range(9) == 0) ? CRC_BITS'($urandom_range(1, 63)) : '0;
            send_frame(build_frame(pos, 1'($urandom), 1'($urandom), 1'($urandom), flip,
                                   $urandom_range(31, 61), random_raw()));
        end
        calm = 1'b0;
        wait_all_decoded();
    endtask

    task automatic test_random_mix();
        logic [POSITION_BITS-1:0] pos;
        logic [CRC_BITS-1:0]      flip;
        logic [RAW_BITS-1:0]      raw;
        int                       msb;
        int                       pick;
        int                       n;
        for (n = 0; n < MIX_FRAMES; n++)
        begin
            case ($urandom_range(9))
                0: pos = '0;
                1: pos = POS_MAX;
                2: pos = last_position + HALF_TURN;
                3: pos = last_position + HALF_TURN + 1'b1;
                4: pos = last_position - HALF_TURN - 1'b1;
                5, 6: pos = last_position + POSITION_BITS'($urandom_range(0, 2 ** 21))
                            - POSITION_BITS'(2 ** 20);
                default: pos = POSITION_BITS'($urandom);
            endcase
            pick = $urandom_range(9);
            msb = (pick < 6) ? 61 : (pick < 8) ? $urandom_range(31, 60) : $urandom_range(0, 30);
            flip = ($urandom_range(6) == 0) ? CRC_BITS'($urandom_range(1, 63)) : '0;
            raw = build_frame(pos, 1'($urandom), 1'($urandom), 1'($urandom), flip, msb,
                              random_raw());
            pick = $urandom_range(19);
            if (pick == 0)
                raw = random_raw();
            else if (pick == 1)
                raw = {2'($urandom), 62'b0};
            else if (pick == 2)
                raw[$urandom_range(0, 61)] ^= 1'b1;
            send_frame(raw);
        end
        wait_all_decoded();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_start();
        test_field_extremes();
        test_start_bit_placement();
        test_half_turn();
        test_turn_wrap();
        test_random_mix();
        repeat (8) @(posedge clk);
        $display("Decoded %0d frames: %0d with CRC errors, %0d without a start bit.",
                 frames_sent, bad_crc_frames, startless_frames);
        $display("Turn counter changed sign %0d times; %0d mismatches found.",
                 sign_flips, errors);
        if (errors == 0 && pending_decodes.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/bcfd_pkg.sv
rtl/core/bcfd_front.sv
rtl/core/bcfd_queue.sv
rtl/core/bcfd_back.sv
rtl/core/biss_c_frame_decoder_top.sv
test/tb.sv
